### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the skip condition unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/scu_pkg.sv
// ----------------------------------------------------------------------------
// scu_pkg
// Types, operation codes and constants of the skip condition unit.
// ----------------------------------------------------------------------------
package scu_pkg;

   localparam int OPERATION_W = 6;
   localparam int WORD_W      = 16;
   localparam int LONG_W      = 32;
   localparam int BIT_NUM_W   = 4;
   localparam int SKIP_W      = 2;
   localparam int TARGET_W    = 2;

   localparam logic [WORD_W-1:0] SW1_MASK    = 16'o100000;
   localparam logic [WORD_W-1:0] SW2_MASK    = 16'o040000;
   localparam logic [WORD_W-1:0] SW3_MASK    = 16'o020000;
   localparam logic [WORD_W-1:0] SW4_MASK    = 16'o010000;
   localparam logic [WORD_W-1:0] SW_ANY_MASK = 16'o170000;
   localparam logic [WORD_W-1:0] WORD_MSB    = 16'h8000;
   localparam logic [LONG_W-1:0] WORD_SIGN   = 32'h0000_8000;
   localparam logic [LONG_W-1:0] LONG_SIGN   = 32'h8000_0000;

   localparam logic [SKIP_W-1:0] SKIP_NONE = 2'd0;
   localparam logic [SKIP_W-1:0] SKIP_ONE  = 2'd1;
   localparam logic [SKIP_W-1:0] SKIP_TWO  = 2'd2;

   typedef enum logic [TARGET_W-1:0] {
      TGT_NONE   = 2'd0,
      TGT_INDEX  = 2'd1,
      TGT_MEMORY = 2'd2
   } count_target_type;

   typedef enum logic [OPERATION_W-1:0] {
      OP_SS1, OP_SR1, OP_SS2, OP_SR2, OP_SS3, OP_SR3, OP_SS4, OP_SR4,
      OP_SSS, OP_SSR, OP_NOP, OP_SGT, OP_SKP, OP_SLE, OP_SLN, OP_SLZ,
      OP_SMCR, OP_SMCS, OP_SMI, OP_SNZ, OP_SPL, OP_SRC, OP_SSC, OP_SZE,
      OP_SAR, OP_SAS, OP_SNR, OP_SNS, OP_CAZ, OP_CAS, OP_CLS, OP_IRX,
      OP_DRX, OP_IRS
   } opcode_type;

   typedef struct packed {
      logic [OPERATION_W-1:0] operation;
      logic [WORD_W-1:0]      accumulator;
      logic [LONG_W-1:0]      long_register;
      logic [LONG_W-1:0]      memory_operand;
      logic [WORD_W-1:0]      index_register;
      logic                   carry_bit;
      logic [BIT_NUM_W-1:0]   bit_number;
   } request_type;

   typedef struct packed {
      logic [SKIP_W-1:0]   skip_count;
      logic                link_write;
      logic                new_link;
      logic                cc_write;
      logic                cc_less;
      logic                cc_equal;
      logic [TARGET_W-1:0] count_target;
      logic [WORD_W-1:0]   count_value;
   } result_type;

endpackage

### rtl/scu_req_if.sv
// ----------------------------------------------------------------------------
// scu_req_if
// Request channel: one skip-class instruction and its operands.
// ----------------------------------------------------------------------------
interface scu_req_if;
   logic                             valid;
   logic                             ready;
   logic [scu_pkg::OPERATION_W-1:0]  operation;
   logic [scu_pkg::WORD_W-1:0]       accumulator;
   logic [scu_pkg::LONG_W-1:0]       long_register;
   logic [scu_pkg::LONG_W-1:0]       memory_operand;
   logic [scu_pkg::WORD_W-1:0]       index_register;
   logic                             carry_bit;
   logic [scu_pkg::BIT_NUM_W-1:0]    bit_number;

   modport source (
      output valid, operation, accumulator, long_register, memory_operand,
             index_register, carry_bit, bit_number,
      input  ready
   );

   modport sink (
      input  valid, operation, accumulator, long_register, memory_operand,
             index_register, carry_bit, bit_number,
      output ready
   );
endinterface

### rtl/scu_rsp_if.sv
// ----------------------------------------------------------------------------
// scu_rsp_if
// Response channel: skip count, link and condition codes, count update.
// ----------------------------------------------------------------------------
interface scu_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [scu_pkg::SKIP_W-1:0]      skip_count;
   logic                            link_write;
   logic                            new_link;
   logic                            cc_write;
   logic                            cc_less;
   logic                            cc_equal;
   logic [scu_pkg::TARGET_W-1:0]    count_target;
   logic [scu_pkg::WORD_W-1:0]      count_value;

   modport source (
      output valid, skip_count, link_write, new_link, cc_write, cc_less,
             cc_equal, count_target, count_value,
      input  ready
   );

   modport sink (
      input  valid, skip_count, link_write, new_link, cc_write, cc_less,
             cc_equal, count_target, count_value,
      output ready
   );
endinterface

### rtl/scu_eval.sv
// ----------------------------------------------------------------------------
// scu_eval
// Decodes one registered request and evaluates its skip condition, compare
// or count operation.
// ----------------------------------------------------------------------------
module scu_eval (
   input  scu_pkg::request_type        request,
   input  logic [scu_pkg::WORD_W-1:0]  sense_switches,
   output scu_pkg::result_type         result
);
   import scu_pkg::*;

   logic [WORD_W-1:0] bit_mask;
   logic              acc_neg;
   logic              acc_zero;
   logic [LONG_W-1:0] cmp_lhs;
   logic [LONG_W-1:0] cmp_rhs;
   logic [LONG_W-1:0] cmp_sign;
   logic              cmp_less;
   logic              cmp_equal;
   logic              cmp_carry;
   logic [WORD_W-1:0] cnt_base;
   logic [WORD_W-1:0] cnt_step;
   logic [WORD_W-1:0] cnt_value;
   logic              skip;
   logic              is_compare;
   logic              is_count;

   assign bit_mask = WORD_MSB >> request.bit_number;
   assign acc_neg  = request.accumulator[WORD_W-1];
   assign acc_zero = (request.accumulator == '0);

   always_comb begin
      if (request.operation == OP_CLS) begin
         cmp_lhs  = request.long_register;
         cmp_rhs  = request.memory_operand;
         cmp_sign = LONG_SIGN;
      end else begin
         cmp_lhs  = {{(LONG_W-WORD_W){1'b0}}, request.accumulator};
         cmp_sign = WORD_SIGN;
         if (request.operation == OP_CAZ) begin
            cmp_rhs = '0;
         end else begin
            cmp_rhs = {{(LONG_W-WORD_W){1'b0}}, request.memory_operand[WORD_W-1:0]};
         end
      end
   end

   // Flipping the sign bit turns a signed order into an unsigned one.
   assign cmp_less  = ((cmp_lhs ^ cmp_sign) < (cmp_rhs ^ cmp_sign));
   assign cmp_equal = (cmp_lhs == cmp_rhs);
   assign cmp_carry = (cmp_lhs >= cmp_rhs);

   always_comb begin
      if (request.operation == OP_IRS) begin
         cnt_base = request.memory_operand[WORD_W-1:0];
      end else begin
         cnt_base = request.index_register;
      end
      if (request.operation == OP_DRX) begin
         cnt_step = '1;
      end else begin
         cnt_step = WORD_W'(1);
      end
   end

   assign cnt_value = cnt_base + cnt_step;

   always_comb begin
      skip       = 1'b0;
      is_compare = 1'b0;
      is_count   = 1'b0;
      unique case (request.operation)
         OP_SS1:  skip = ((sense_switches & SW1_MASK) != '0);
         OP_SR1:  skip = ((sense_switches & SW1_MASK) == '0);
         OP_SS2:  skip = ((sense_switches & SW2_MASK) != '0);
         OP_SR2:  skip = ((sense_switches & SW2_MASK) == '0);
         OP_SS3:  skip = ((sense_switches & SW3_MASK) != '0);
         OP_SR3:  skip = ((sense_switches & SW3_MASK) == '0);
         OP_SS4:  skip = ((sense_switches & SW4_MASK) != '0);
         OP_SR4:  skip = ((sense_switches & SW4_MASK) == '0);
         OP_SSS:  skip = ((sense_switches & SW_ANY_MASK) != '0);
         OP_SSR:  skip = ((sense_switches & SW_ANY_MASK) == '0);
         OP_NOP:  skip = 1'b0;
         OP_SGT:  skip = !acc_neg && !acc_zero;
         OP_SKP:  skip = 1'b1;
         OP_SLE:  skip = acc_neg || acc_zero;
         OP_SLN:  skip = request.accumulator[0];
         OP_SLZ:  skip = !request.accumulator[0];
         OP_SMCR: skip = 1'b1;
         OP_SMCS: skip = 1'b0;
         OP_SMI:  skip = acc_neg;
         OP_SNZ:  skip = !acc_zero;
         OP_SPL:  skip = !acc_neg;
         OP_SRC:  skip = !request.carry_bit;
         OP_SSC:  skip = request.carry_bit;
         OP_SZE:  skip = acc_zero;
         OP_SAR:  skip = ((request.accumulator & bit_mask) == '0);
         OP_SAS:  skip = ((request.accumulator & bit_mask) != '0);
         OP_SNR:  skip = ((sense_switches & bit_mask) == '0);
         OP_SNS:  skip = ((sense_switches & bit_mask) != '0);
         OP_CAZ, OP_CAS, OP_CLS: is_compare = 1'b1;
         OP_IRX, OP_DRX, OP_IRS: is_count = 1'b1;
         default: skip = 1'b0;
      endcase
   end

   always_comb begin
      result = '0;
      if (is_compare) begin
         if (cmp_less) begin
            result.skip_count = SKIP_TWO;
         end else if (cmp_equal) begin
            result.skip_count = SKIP_ONE;
         end else begin
            result.skip_count = SKIP_NONE;
         end
         result.link_write = 1'b1;
         result.new_link   = cmp_carry;
         result.cc_write   = 1'b1;
         result.cc_less    = cmp_less;
         result.cc_equal   = cmp_equal;
      end else if (is_count) begin
         result.skip_count   = (cnt_value == '0) ? SKIP_ONE : SKIP_NONE;
         result.count_target = (request.operation == OP_IRS) ? TGT_MEMORY : TGT_INDEX;
         result.count_value  = cnt_value;
      end else begin
         result.skip_count = skip ? SKIP_ONE : SKIP_NONE;
      end
   end

endmodule

### rtl/skip_condition_unit_top.sv
// ----------------------------------------------------------------------------
// skip_condition_unit_top
// Path: an accepted request is held in the input register, and its evaluated
//    result moves into the response register, which drives the response.
// Throughput: one request per cycle; the input stalls only when both the input
//    and the response register hold a request and the response is not taken.
// Reset clears both valid flags and the sense switch register.
// ----------------------------------------------------------------------------
module skip_condition_unit_top (
   input  logic                        clock,
   input  logic                        reset,
   scu_req_if.sink                     req_channel,
   scu_rsp_if.source                   rsp_channel,
   input  logic                        csr_write_enable,
   input  logic [scu_pkg::WORD_W-1:0]  csr_write_data
);
   import scu_pkg::*;
   `include "assert_macros.svh"

   logic              sense_write;
   logic [WORD_W-1:0] sense_switches_ff;
   logic [WORD_W-1:0] sense_switches_in;
   logic              req_valid_ff;
   logic              req_valid_in;
   request_type       req_data_ff;
   request_type       req_data_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_data_ff;
   result_type        rsp_data_in;
   request_type       req_payload;
   result_type        eval_result;
   logic              rsp_take;
   logic              req_take;
   logic              req_accept;
   logic              eval_load;
   logic              rsp_kinds_ok;

   assign req_payload.operation      = req_channel.operation;
   assign req_payload.accumulator    = req_channel.accumulator;
   assign req_payload.long_register  = req_channel.long_register;
   assign req_payload.memory_operand = req_channel.memory_operand;
   assign req_payload.index_register = req_channel.index_register;
   assign req_payload.carry_bit      = req_channel.carry_bit;
   assign req_payload.bit_number     = req_channel.bit_number;

   assign rsp_take = !rsp_valid_ff || rsp_channel.ready;
   assign req_take = !req_valid_ff || rsp_take;
   assign req_channel.ready = req_take;

   assign sense_write = csr_write_enable;

   always_comb begin
      sense_switches_in = sense_write ? csr_write_data : sense_switches_ff;
      req_valid_in      = req_take ? req_channel.valid : req_valid_ff;
      req_data_in       = (req_take && req_channel.valid) ? req_payload : req_data_ff;
      rsp_valid_in      = rsp_take ? req_valid_ff : rsp_valid_ff;
      rsp_data_in       = (rsp_take && req_valid_ff) ? eval_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sense_switches_ff <= '0;
         req_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         sense_switches_ff <= sense_switches_in;
         req_valid_ff      <= req_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   scu_eval u_eval (
      .request        (req_data_ff),
      .sense_switches (sense_switches_ff),
      .result         (eval_result)
   );

   assign rsp_channel.valid        = rsp_valid_ff;
   assign rsp_channel.skip_count   = rsp_data_ff.skip_count;
   assign rsp_channel.link_write   = rsp_data_ff.link_write;
   assign rsp_channel.new_link     = rsp_data_ff.new_link;
   assign rsp_channel.cc_write     = rsp_data_ff.cc_write;
   assign rsp_channel.cc_less      = rsp_data_ff.cc_less;
   assign rsp_channel.cc_equal     = rsp_data_ff.cc_equal;
   assign rsp_channel.count_target = rsp_data_ff.count_target;
   assign rsp_channel.count_value  = rsp_data_ff.count_value;

   assign req_accept   = req_channel.valid && req_take;
   assign eval_load    = req_valid_ff && rsp_take;
   assign rsp_kinds_ok = (rsp_data_ff.link_write == rsp_data_ff.cc_write) &&
                         !(rsp_data_ff.cc_write && (rsp_data_ff.count_target != TGT_NONE));

   `ASSERT_NEXT(a_accept_fills_input, clock, reset, req_accept, req_valid_ff, "request lost")
   `ASSERT_NEXT(a_input_moves_out, clock, reset, eval_load, rsp_valid_ff, "response lost")
   `ASSERT_NEXT(a_payload, clock, reset, eval_load, rsp_data_ff == $past(eval_result), "bad data")
   `ASSERT_ALWAYS(a_result_kinds, clock, reset, !rsp_valid_ff || rsp_kinds_ok, "kinds overlap")

endmodule
